### sv/arl_pkg.sv
// ----------------------------------------------------------------------------
// arl_pkg
// Shared types, constants and the sine and cosine tables for the roll angle block.
// ----------------------------------------------------------------------------
package arl_pkg;

    localparam int CORDIC_STAGES_DEF = 24;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int DEG_W    = 7;
    localparam int ROLL_W   = 8;
    localparam int ROM_W    = 63;
    localparam int ROM_DEPTH = 2 ** DEG_W;
    localparam int MUL_LO_W = 32;

    localparam logic [DEG_W-1:0] MAX_DEG   = DEG_W'(89);
    localparam logic [DEG_W-1:0] RIGHT_DEG = DEG_W'(90);
    localparam int HALF_DEG = 45;

    localparam logic [127:0] DEC_ONE  = 128'd1000000000000000000;
    localparam logic [127:0] COS1_DEC = 128'd999847695156391239;
    localparam logic [127:0] SIN1_DEC = 128'd17452406437283513;

    // one degree rotation in q0.62, truncated
    localparam logic [63:0] COS1_Q62 = 64'((COS1_DEC << 62) / DEC_ONE);
    localparam logic [63:0] SIN1_Q62 = 64'((SIN1_DEC << 62) / DEC_ONE);

    typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] trig_tab_t;

    typedef struct packed {
        logic             neg;
        logic             undef;
        logic             a_zero;
        logic             b_zero;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic [DEG_W-1:0] deg;
    } arl_item_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    // table by repeated rotation; entry 45 of the sine table takes the cosine value
    function automatic trig_tab_t build_tab(input logic want_sin);
        trig_tab_t   tab;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] cn;
        logic [63:0] sn;
        tab = '0;
        c = 64'd1 << 62;
        s = 64'd0;
        tab[0] = want_sin ? ROM_W'(s) : ROM_W'(c);
        for (int k = 1; k <= 89; k++)
        begin
            cn = mul_q62(c, COS1_Q62) - mul_q62(s, SIN1_Q62);
            sn = mul_q62(s, COS1_Q62) + mul_q62(c, SIN1_Q62);
            c = cn;
            s = sn;
            if (want_sin && k != HALF_DEG)
                tab[k[DEG_W-1:0]] = ROM_W'(s);
            else
                tab[k[DEG_W-1:0]] = ROM_W'(c);
        end
        return tab;
    endfunction

    localparam trig_tab_t COS_TAB = build_tab(1'b0);
    localparam trig_tab_t SIN_TAB = build_tab(1'b1);

endpackage

### sv/arl_sample_if.sv
// ----------------------------------------------------------------------------
// arl_sample_if
// Request channel carrying one x/z acceleration sample pair.
// ----------------------------------------------------------------------------
interface arl_sample_if;

    logic                                valid;
    logic                                ready;
    logic signed [arl_pkg::SAMPLE_W-1:0] x_accel;
    logic signed [arl_pkg::SAMPLE_W-1:0] z_accel;

    modport source (output valid, output x_accel, output z_accel, input ready);
    modport sink (input valid, input x_accel, input z_accel, output ready);

endinterface

### sv/arl_result_if.sv
// ----------------------------------------------------------------------------
// arl_result_if
// Result channel carrying the roll angle and the undefined flag.
// ----------------------------------------------------------------------------
interface arl_result_if;

    logic                              valid;
    logic                              ready;
    logic signed [arl_pkg::ROLL_W-1:0] roll_degrees;
    logic                              angle_undefined;

    modport source (output valid, output roll_degrees, output angle_undefined, input ready);
    modport sink (input valid, input roll_degrees, input angle_undefined, output ready);

endinterface

### sv/accel_roll_angle.sv
// ----------------------------------------------------------------------------
// accel_roll_angle
// Roll angle in whole degrees from one x/z acceleration sample pair.
// ----------------------------------------------------------------------------
// sample: request channel, one signed x/z pair per request
// result: roll_degrees = atan(x/z) truncated toward zero, -90..90, plus
//   angle_undefined when both samples are zero (angle then 0)
// z zero with x nonzero gives +90 or -90 after the sign of x
// latency: a request passes the input register, the search steps and the output register
// throughput: one request per cycle while sample.ready is high, through a 7-step binary
//   search over the degree table, each step a table read, a split multiply and a wide
//   compare in three registered stages
// reset: all valid bits clear, the block is empty and ready
// stall: with the result held, the pipeline keeps moving until the skid
//   register also holds an item; sample.ready then drops until it drains
// ----------------------------------------------------------------------------
module accel_roll_angle #(
    parameter int CORDIC_STAGES = arl_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    arl_sample_if.sink          sample,
    arl_result_if.source        result
);

    localparam int DEG_W = arl_pkg::DEG_W;

    logic                      en;
    logic                      s0_valid_reg;
    arl_pkg::arl_item_t        s0_item_reg;
    arl_pkg::arl_item_t        s0_item_next;

    logic                      chain_valid [0:DEG_W];
    arl_pkg::arl_item_t        chain_item [0:DEG_W];

    logic                      prod;
    logic signed [arl_pkg::ROLL_W-1:0] roll_next;
    logic [DEG_W-1:0]          mag;

    logic                      out_valid_reg;
    logic signed [arl_pkg::ROLL_W-1:0] out_roll_reg;
    logic                      out_undef_reg;
    logic                      skid_valid_reg;
    logic signed [arl_pkg::ROLL_W-1:0] skid_roll_reg;
    logic                      skid_undef_reg;

    assign en           = !skid_valid_reg;
    assign sample.ready = en;

    // magnitudes and sign
    always_comb
    begin
        s0_item_next.neg    = sample.x_accel[arl_pkg::SAMPLE_W-1]
                              ^ sample.z_accel[arl_pkg::SAMPLE_W-1];
        s0_item_next.a      = sample.x_accel[arl_pkg::SAMPLE_W-1]
                              ? arl_pkg::MAG_W'(-$signed({sample.x_accel[arl_pkg::SAMPLE_W-1],
                                                          sample.x_accel}))
                              : arl_pkg::MAG_W'(sample.x_accel);
        s0_item_next.b      = sample.z_accel[arl_pkg::SAMPLE_W-1]
                              ? arl_pkg::MAG_W'(-$signed({sample.z_accel[arl_pkg::SAMPLE_W-1],
                                                          sample.z_accel}))
                              : arl_pkg::MAG_W'(sample.z_accel);
        s0_item_next.a_zero = sample.x_accel == '0;
        s0_item_next.b_zero = sample.z_accel == '0;
        s0_item_next.undef  = (sample.x_accel == '0) && (sample.z_accel == '0);
        s0_item_next.deg    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_item_reg <= s0_item_next;
    end

    assign chain_valid[0] = s0_valid_reg;
    assign chain_item[0]  = s0_item_reg;

    for (genvar i = 0; i < DEG_W; i++)
    begin : g_step
        arl_search_step #(
            .CORDIC_STAGES (CORDIC_STAGES),
            .STEP_BIT      (DEG_W - 1 - i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    // special cases and sign
    always_comb
    begin
        priority if (chain_item[DEG_W].undef || chain_item[DEG_W].a_zero)
            mag = '0;
        else if (chain_item[DEG_W].b_zero)
            mag = arl_pkg::RIGHT_DEG;
        else
            mag = chain_item[DEG_W].deg;
        if (chain_item[DEG_W].neg)
            roll_next = -$signed(arl_pkg::ROLL_W'(mag));
        else
            roll_next = $signed(arl_pkg::ROLL_W'(mag));
    end

    assign prod = en && chain_valid[DEG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (prod)
        begin
            if (out_valid_reg && !result.ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_roll_reg  <= skid_roll_reg;
                out_undef_reg <= skid_undef_reg;
            end
        end
        else if (prod)
        begin
            if (out_valid_reg && !result.ready)
            begin
                skid_roll_reg  <= roll_next;
                skid_undef_reg <= chain_item[DEG_W].undef;
            end
            else
            begin
                out_roll_reg  <= roll_next;
                out_undef_reg <= chain_item[DEG_W].undef;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.roll_degrees    = out_roll_reg;
    assign result.angle_undefined = out_undef_reg;

endmodule

### sv/arl_search_step.sv
// ----------------------------------------------------------------------------
// arl_search_step
// One bit of the degree search: table read, products, compare. Three stages.
// ----------------------------------------------------------------------------
module arl_search_step #(
    parameter int CORDIC_STAGES = arl_pkg::CORDIC_STAGES_DEF,
    parameter int STEP_BIT      = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  arl_pkg::arl_item_t in_item,
    output logic               out_valid,
    output arl_pkg::arl_item_t out_item
);

    localparam int SHIFT = 32 - CORDIC_STAGES;
    localparam int CW    = arl_pkg::ROM_W - SHIFT;
    localparam int LO_W  = arl_pkg::MUL_LO_W;
    localparam int HI_W  = CW - LO_W;
    localparam int PH_W  = arl_pkg::MAG_W + HI_W;
    localparam int PL_W  = arl_pkg::MAG_W + LO_W;
    localparam int PW    = arl_pkg::MAG_W + CW;
    localparam logic [arl_pkg::DEG_W-1:0] BIT_MASK = arl_pkg::DEG_W'(1) << STEP_BIT;

    // table read stage
    logic [arl_pkg::DEG_W-1:0] cand;
    logic                      r_valid_reg;
    arl_pkg::arl_item_t        r_item_reg;
    logic [arl_pkg::DEG_W-1:0] r_cand_reg;
    logic                      r_ok_reg;
    logic [CW-1:0]             r_cos_reg;
    logic [CW-1:0]             r_sin_reg;

    // product stage
    logic                      m_valid_reg;
    arl_pkg::arl_item_t        m_item_reg;
    logic [arl_pkg::DEG_W-1:0] m_cand_reg;
    logic                      m_ok_reg;
    logic [PH_W-1:0]           m_ac_hi_reg;
    logic [PL_W-1:0]           m_ac_lo_reg;
    logic [PH_W-1:0]           m_bs_hi_reg;
    logic [PL_W-1:0]           m_bs_lo_reg;

    // compare stage
    logic [PW:0]               lhs;
    logic [PW:0]               rhs;
    arl_pkg::arl_item_t        c_item_next;
    logic                      c_valid_reg;
    arl_pkg::arl_item_t        c_item_reg;

    assign cand = in_item.deg | BIT_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg <= in_valid;
            m_valid_reg <= r_valid_reg;
            c_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_item_reg <= in_item;
            r_cand_reg <= cand;
            r_ok_reg   <= cand <= arl_pkg::MAX_DEG;
            r_cos_reg  <= CW'(arl_pkg::COS_TAB[cand] >> SHIFT);
            r_sin_reg  <= CW'(arl_pkg::SIN_TAB[cand] >> SHIFT);

            m_item_reg  <= r_item_reg;
            m_cand_reg  <= r_cand_reg;
            m_ok_reg    <= r_ok_reg;
            m_ac_hi_reg <= PH_W'(r_item_reg.a) * PH_W'(r_cos_reg[CW-1:LO_W]);
            m_ac_lo_reg <= PL_W'(r_item_reg.a) * PL_W'(r_cos_reg[LO_W-1:0]);
            m_bs_hi_reg <= PH_W'(r_item_reg.b) * PH_W'(r_sin_reg[CW-1:LO_W]);
            m_bs_lo_reg <= PL_W'(r_item_reg.b) * PL_W'(r_sin_reg[LO_W-1:0]);

            c_item_reg <= c_item_next;
        end
    end

    always_comb
    begin
        lhs = (PW + 1)'({m_ac_hi_reg, {LO_W{1'b0}}}) + (PW + 1)'(m_ac_lo_reg);
        rhs = (PW + 1)'({m_bs_hi_reg, {LO_W{1'b0}}}) + (PW + 1)'(m_bs_lo_reg);
        c_item_next = m_item_reg;
        if (m_ok_reg && (lhs >= rhs))
            c_item_next.deg = m_cand_reg;
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

### tb/sv/accel_roll_angle_tb.sv
// ----------------------------------------------------------------------------
// accel_roll_angle_tb
// Self-checking bench for the roll angle block. Directed corner pairs and
// random x/z requests go in through a queue-fed driver. Each accepted request
// is predicted by exact integer compares against a sine and cosine table built here. A monitor
// checks every result in order under random stalls on both channels, with one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module accel_roll_angle_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = arl_pkg::CORDIC_STAGES_DEF;
    localparam int TRUNC_SH   = 32 - STAGES;
    localparam int N_RANDOM   = 550;
    localparam int HOLD_LEN   = 150;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic signed [arl_pkg::SAMPLE_W-1:0] x;
        logic signed [arl_pkg::SAMPLE_W-1:0] z;
    } xz_pair_t;

    typedef struct packed {
        logic signed [arl_pkg::ROLL_W-1:0] roll;
        logic                              undef;
    } roll_exp_t;

    logic clk = 1'b0;
    logic rst_n;

    arl_sample_if sample ();
    arl_result_if result ();

    accel_roll_angle #(.CORDIC_STAGES(STAGES)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result)
    );

    logic [63:0] trig_cos [0:89];
    logic [63:0] trig_sin [0:89];

    xz_pair_t  pend_q [$];
    roll_exp_t roll_q [$];

    int n_total   = 1;
    int n_taken;
    int err_count = 0;
    int hold_at   = 0;
    int hold_left;
    bit hold_done;
    int send_idle;
    int recv_idle;

    assign send_idle = (n_taken < n_total / 3) ? 18 : (n_taken < 2 * n_total / 3) ? 45 : 0;
    assign recv_idle = (n_taken < n_total / 3) ? 45 : (n_taken < 2 * n_total / 3) ? 18 : 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic roll_exp_t predict_roll(input xz_pair_t p);
        int           ax;
        int           bz;
        int           deg;
        bit           going;
        logic [127:0] lhs;
        logic [127:0] rhs;
        roll_exp_t    r;
        ax = p.x;
        bz = p.z;
        if (ax < 0)
            ax = -ax;
        if (bz < 0)
            bz = -bz;
        deg = 0;
        r.undef = 1'b0;
        if (ax == 0 && bz == 0)
            r.undef = 1'b1;
        else if (bz == 0)
            deg = 90;
        else if (ax != 0)
        begin
            going = 1'b1;
            for (int k = 1; k < 90 && going; k++)
            begin
                lhs = 128'(ax) * 128'(trig_cos[k] >> TRUNC_SH);
                rhs = 128'(bz) * 128'(trig_sin[k] >> TRUNC_SH);
                if (lhs >= rhs)
                    deg = k;
                else
                    going = 1'b0;
            end
        end
        if ((p.x[arl_pkg::SAMPLE_W-1] != p.z[arl_pkg::SAMPLE_W-1]) && deg != 0)
            r.roll = arl_pkg::ROLL_W'(-deg);
        else
            r.roll = arl_pkg::ROLL_W'(deg);
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid   <= 1'b0;
            sample.x_accel <= '0;
            sample.z_accel <= '0;
            n_taken        <= 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                roll_q.push_back(predict_roll({sample.x_accel, sample.z_accel}));
                n_taken <= n_taken + 1;
            end
            if (!sample.valid || sample.ready)
            begin
                if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    sample.valid   <= 1'b1;
                    sample.x_accel <= pend_q[0].x;
                    sample.z_accel <= pend_q[0].z;
                    void'(pend_q.pop_front());
                end
                else
                    sample.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && hold_at != 0 && n_taken >= hold_at)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (roll_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual roll %0d undef %0b",
                         $time, result.roll_degrees, result.angle_undefined);
                err_count++;
            end
            else
            begin
                if (result.roll_degrees !== roll_q[0].roll)
                begin
                    $display("%0t roll_degrees mismatch: expected %0d, actual %0d",
                             $time, roll_q[0].roll, result.roll_degrees);
                    err_count++;
                end
                if (result.angle_undefined !== roll_q[0].undef)
                begin
                    $display("%0t angle_undefined mismatch: expected %0b, actual %0b",
                             $time, roll_q[0].undef, result.angle_undefined);
                    err_count++;
                end
                void'(roll_q.pop_front());
            end
        end
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [127:0] one_dec;
        logic [127:0] c1;
        logic [127:0] s1;
        logic [127:0] pc;
        logic [127:0] ps;
        logic [127:0] qc;
        logic [127:0] qs;
        logic [127:0] t;
        int           dir_x [] = '{0, 1, -1, 0, 0, 32767, -32768, -32768, 32767, -32768,
                                   0, 1, 32767, -32768, 1, 1, -5, 7, -32768, 32767,
                                   1, -1, 3};
        int           dir_z [] = '{0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, 0,
                                   -32768, 32767, 1, 1, 1, -1, 5, -7, -1, 0,
                                   -32768, 32767, 0};
        int           kind;
        int           xv;
        int           zv;
        int           k;

        rst_n = 1'b0;

        // sine and cosine table by repeated one degree rotation in q0.62
        one_dec = 128'd1000000000000000000;
        c1 = (128'd999847695156391239 << 62) / one_dec;
        s1 = (128'd17452406437283513 << 62) / one_dec;
        trig_cos[0] = 64'd1 << 62;
        trig_sin[0] = 64'd0;
        for (int i = 1; i < 90; i++)
        begin
            pc = 128'(trig_cos[i-1]) * c1;
            ps = 128'(trig_sin[i-1]) * s1;
            qc = 128'(trig_sin[i-1]) * c1;
            qs = 128'(trig_cos[i-1]) * s1;
            trig_cos[i] = pc[125:62] - ps[125:62];
            trig_sin[i] = qc[125:62] + qs[125:62];
        end
        trig_sin[45] = trig_cos[45];

        foreach (dir_x[i])
            pend_q.push_back({arl_pkg::SAMPLE_W'(dir_x[i]), arl_pkg::SAMPLE_W'(dir_z[i])});

        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                xv = $signed(16'($urandom));
                zv = $signed(16'($urandom));
            end
            else if (kind < 50)
            begin
                xv = $urandom_range(0, 40) - 20;
                zv = $urandom_range(0, 40) - 20;
            end
            else if (kind < 85)
            begin
                // ratio close to the tangent of a whole degree
                k  = $urandom_range(1, 89);
                zv = $urandom_range(1, 32767);
                t  = (128'(zv) * 128'(trig_sin[k])) / 128'(trig_cos[k]);
                xv = (t > 128'd32767) ? 32767 : int'(t);
                xv = xv + $urandom_range(0, 4) - 2;
                if (xv < 0)
                    xv = 0;
                if (xv > 32767)
                    xv = 32767;
                if ($urandom_range(0, 1))
                    xv = -xv;
                if ($urandom_range(0, 1))
                    zv = -zv;
                if ($urandom_range(0, 1))
                begin
                    t  = 128'(xv);
                    xv = zv;
                    zv = int'(t);
                end
            end
            else if (kind < 95)
            begin
                xv = $signed(16'($urandom));
                zv = 0;
                if ($urandom_range(0, 1))
                begin
                    zv = xv;
                    xv = 0;
                end
            end
            else
            begin
                xv = $urandom_range(0, 1) ? -32768 : 0;
                zv = $urandom_range(0, 1) ? -32768 : 0;
            end
            pend_q.push_back({arl_pkg::SAMPLE_W'(xv), arl_pkg::SAMPLE_W'(zv)});
        end

        n_total = pend_q.size();
        hold_at = (n_total * 3) / 4;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pend_q.size() != 0 || sample.valid)
            @(posedge clk);
        while (roll_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0 && roll_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
